>>> rtl/svm_pkg.sv
// Shared types, codes and constants of the stack machine execute unit.
package svm_pkg;

    localparam int DEF_MEM_WORDS  = 1024;
    localparam int DEF_PROG_WORDS = 65536;
    localparam int PC_W           = 16;
    localparam int WORD_W         = 64;

    typedef enum logic [4:0] {
        OP_IMM, OP_LC, OP_LI, OP_SC, OP_SI, OP_PUSH, OP_POP, OP_JMP,
        OP_JZ, OP_JNZ, OP_CALL, OP_ENT, OP_ADJ, OP_LEV, OP_LEA, OP_OR,
        OP_XOR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
        OP_SHL, OP_SHR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EXIT
    } op_t;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_EXIT  = 3'd1;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_STACK = 3'd4;
    localparam logic [2:0] ST_ADDR  = 3'd5;

    typedef enum logic [1:0] {
        SRC_PLAIN, SRC_MUL, SRC_DIV
    } acc_src_t;

    typedef enum logic [3:0] {
        CS_CLEAR, CS_IDLE, CS_RD1, CS_CAP1, CS_CAP2, CS_EXEC, CS_MUL, CS_DIV, CS_WB
    } ctl_state_t;

    typedef struct packed {
        logic load_item;
        logic rd1;
        logic rd2;
        logic cap1;
        logic cap2;
        logic plan;
        logic mul_go;
        logic div_go;
        logic commit;
        logic clr_step;
    } svm_cmd_t;

    typedef struct packed {
        logic need2;
        logic go_mul;
        logic go_div;
        logic mul_done;
        logic div_done;
        logic clr_last;
        logic cfg_busy;
        logic out_free;
    } svm_sts_t;

endpackage

>>> rtl/svm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module svm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/svm_div.sv
// Signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
module svm_div
    import svm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              is_mod,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    logic              busy_reg, fin_reg, done_reg;
    logic [5:0]        cnt_reg;
    logic [WORD_W-1:0] rem_reg, quo_reg, ub_reg, res_reg;
    logic              neg_q_reg, neg_r_reg, mod_reg;
    logic [WORD_W:0]   rem_sh, diff;

    assign rem_sh = {rem_reg, quo_reg[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, ub_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd63) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg   <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            ub_reg    <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            neg_q_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
            neg_r_reg <= dividend[WORD_W-1];
            mod_reg   <= is_mod;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!diff[WORD_W]) begin
                rem_reg <= diff[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            end
        end else if (fin_reg) begin
            if (mod_reg) begin
                res_reg <= neg_r_reg ? (WORD_W'(0) - rem_reg) : rem_reg;
            end else begin
                res_reg <= neg_q_reg ? (WORD_W'(0) - quo_reg) : quo_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/svm_datapath.sv
// Datapath: machine registers, stack memory, multiplier, divider, output register.
module svm_datapath
    import svm_pkg::*;
#(
    parameter int MEM_WORDS  = DEF_MEM_WORDS,
    parameter int PROG_WORDS = DEF_PROG_WORDS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  svm_cmd_t          cmd,
    output svm_sts_t          sts,
    input  logic [4:0]        in_op,
    input  logic [WORD_W-1:0] in_opd,
    input  logic              cfg_wr_en,
    input  logic [PC_W-1:0]   cfg_wr_data,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [143:0]      m_tdata,
    output logic [2:0]        m_tuser
);

    localparam int AW     = $clog2(MEM_WORDS);
    localparam int SPW    = $clog2(MEM_WORDS + 1);
    localparam int MODW   = PC_W + 13;
    localparam logic [WORD_W-1:0] MEM64   = WORD_W'(MEM_WORDS);
    localparam logic [WORD_W-1:0] BYTES64 = WORD_W'(MEM_WORDS) * WORD_W'(8);
    localparam logic [WORD_W-1:0] PW64    = WORD_W'(PROG_WORDS);
    localparam logic [PC_W:0]     PW17    = (PC_W+1)'(PROG_WORDS);
    localparam logic [SPW-1:0]    SP_EMPTY = SPW'(MEM_WORDS);

    // architectural state
    logic [PC_W-1:0]   pc_reg, entry_mod_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [SPW-1:0]    sp_reg, fp_reg;

    // current item and fetched words
    op_t               op_reg;
    logic [WORD_W-1:0] opd_reg, top_reg, w2_reg;

    // config remainder
    logic              mod_busy_reg;
    logic [3:0]        mod_k_reg;
    logic [PC_W-1:0]   mod_rem_reg, mod_rem_next;
    logic [MODW-1:0]   mod_sub;

    // memory
    logic [AW-1:0]     clr_cnt_reg;
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    // plan captured at execute
    logic [WORD_W-1:0] plan_acc_reg, plan_exit_reg, plan_wdata_reg;
    logic [PC_W-1:0]   plan_npc_reg;
    logic [2:0]        plan_st_reg;
    logic [SPW-1:0]    plan_sp_reg, plan_fp_reg;
    logic              plan_we_reg;
    logic [AW-1:0]     plan_waddr_reg;
    acc_src_t          plan_src_reg;

    logic [WORD_W-1:0] x_acc, x_exit, x_wdata;
    logic [PC_W-1:0]   x_npc;
    logic [2:0]        x_st;
    logic [SPW-1:0]    x_sp, x_fp;
    logic              x_we;
    logic [AW-1:0]     x_waddr;
    acc_src_t          x_src;

    // multiplier
    logic              mul_busy_reg, mul_done_reg;
    logic [2:0]        mul_cnt_reg;
    logic [WORD_W-1:0] prod_reg, mul_res_reg, mul_p;
    logic [31:0]       cr1_reg, cr2_reg, mul_x, mul_y;

    // divider
    logic              div_done;
    logic [WORD_W-1:0] div_res;

    // output
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_acc_reg, out_exit_reg, fin_acc;
    logic [PC_W-1:0]   out_npc_reg;
    logic [2:0]        out_st_reg;

    // ---------------- config: entry_pc modulo program size ----------------
    assign mod_sub      = MODW'(PW17) << mod_k_reg;
    assign mod_rem_next = (MODW'(mod_rem_reg) >= mod_sub)
                        ? PC_W'(MODW'(mod_rem_reg) - mod_sub) : mod_rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_busy_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            mod_busy_reg <= 1'b1;
        end else if (mod_busy_reg && mod_k_reg == 4'd0) begin
            mod_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cfg_wr_en) begin
            mod_rem_reg <= cfg_wr_data;
            mod_k_reg   <= 4'd12;
        end else if (mod_busy_reg) begin
            mod_rem_reg <= mod_rem_next;
            mod_k_reg   <= mod_k_reg - 4'd1;
        end
    end

    // ---------------- item latch and fetch ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg  <= op_t'(in_op);
            opd_reg <= in_opd;
        end
        if (cmd.cap1) begin
            top_reg <= ram_rdata;
        end
        if (cmd.cap2) begin
            w2_reg <= ram_rdata;
        end
    end

    always_comb begin
        ram_re    = cmd.rd1 | cmd.rd2;
        ram_raddr = sp_reg[AW-1:0];
        if (cmd.rd2) begin
            if (op_reg == OP_LEV) begin
                ram_raddr = AW'(fp_reg + SPW'(1));
            end else begin
                ram_raddr = ram_rdata[AW+2:3];
            end
        end else begin
            case (op_reg)
                OP_LC, OP_LI: ram_raddr = acc_reg[AW+2:3];
                OP_LEV:       ram_raddr = fp_reg[AW-1:0];
                default:      ram_raddr = sp_reg[AW-1:0];
            endcase
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = plan_waddr_reg;
        ram_wdata = plan_wdata_reg;
        if (cmd.clr_step) begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end else if (cmd.commit && plan_we_reg) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    svm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- execute ----------------
    always_comb begin
        logic              can_pop, take;
        logic [WORD_W-1:0] top, nsp, shb;
        logic [PC_W:0]     n1, n2;
        logic [PC_W-1:0]   npc1, npc2;
        logic [7:0]        lbyte;
        logic [SPW-1:0]    spm1;

        can_pop = sp_reg < SP_EMPTY;
        top     = can_pop ? top_reg : '0;
        n1      = (PC_W+1)'(pc_reg) + (PC_W+1)'(1);
        n2      = (PC_W+1)'(pc_reg) + (PC_W+1)'(2);
        npc1    = (n1 == PW17) ? '0 : PC_W'(n1);
        npc2    = (n2 >= PW17) ? PC_W'(n2 - PW17) : PC_W'(n2);
        spm1    = sp_reg - SPW'(1);
        nsp     = '0;
        take    = 1'b0;
        shb     = '0;
        lbyte   = '0;

        x_acc   = acc_reg;
        x_exit  = '0;
        x_npc   = npc1;
        x_st    = ST_RUN;
        x_sp    = sp_reg;
        x_fp    = fp_reg;
        x_we    = 1'b0;
        x_waddr = spm1[AW-1:0];
        x_wdata = acc_reg;
        x_src   = SRC_PLAIN;

        case (op_reg)
            OP_IMM: begin
                x_acc = opd_reg;
                x_npc = npc2;
            end
            OP_LC, OP_LI: begin
                lbyte = 8'(top_reg >> {acc_reg[2:0], 3'b000});
                if (acc_reg >= BYTES64 || (op_reg == OP_LI && acc_reg[2:0] != 3'd0)) begin
                    x_st = ST_ADDR;
                end else if (op_reg == OP_LI) begin
                    x_acc = top_reg;
                end else begin
                    x_acc = {{56{lbyte[7]}}, lbyte};
                end
            end
            OP_SC, OP_SI: begin
                shb     = {58'd0, top[2:0], 3'b000};
                x_waddr = top[AW+2:3];
                x_sp    = sp_reg + SPW'(1);
                x_we    = 1'b1;
                if (op_reg == OP_SI) begin
                    x_wdata = acc_reg;
                end else begin
                    x_wdata = (w2_reg & ~(64'hFF << shb[5:0]))
                            | ({56'd0, acc_reg[7:0]} << shb[5:0]);
                end
                if (!can_pop) begin
                    x_st = ST_STACK;
                end else if (top >= BYTES64 || (op_reg == OP_SI && top[2:0] != 3'd0)) begin
                    x_st = ST_ADDR;
                end
            end
            OP_PUSH: begin
                x_we = 1'b1;
                x_sp = spm1;
                if (sp_reg == '0) begin
                    x_st = ST_STACK;
                end
            end
            OP_POP: begin
                x_acc = top;
                x_sp  = sp_reg + SPW'(1);
                if (!can_pop) begin
                    x_st = ST_STACK;
                end
            end
            OP_JMP, OP_JZ, OP_JNZ: begin
                take = (op_reg == OP_JMP) || (op_reg == OP_JZ && acc_reg == '0)
                    || (op_reg == OP_JNZ && acc_reg != '0);
                if (!take) begin
                    x_npc = npc2;
                end else if (opd_reg >= PW64) begin
                    x_st = ST_ADDR;
                end else begin
                    x_npc = opd_reg[PC_W-1:0];
                end
            end
            OP_CALL: begin
                x_we    = 1'b1;
                x_wdata = WORD_W'(npc2);
                x_sp    = spm1;
                x_npc   = opd_reg[PC_W-1:0];
                if (sp_reg == '0) begin
                    x_st = ST_STACK;
                end else if (opd_reg >= PW64) begin
                    x_st = ST_ADDR;
                end
            end
            OP_ENT: begin
                nsp     = WORD_W'(spm1) - opd_reg;
                x_we    = 1'b1;
                x_wdata = WORD_W'(fp_reg);
                x_fp    = spm1;
                x_sp    = SPW'(nsp);
                x_npc   = npc2;
                if (sp_reg == '0 || nsp > MEM64) begin
                    x_st = ST_STACK;
                end
            end
            OP_ADJ: begin
                nsp   = WORD_W'(sp_reg) + opd_reg;
                x_sp  = SPW'(nsp);
                x_npc = npc2;
                if (nsp > MEM64) begin
                    x_st = ST_STACK;
                end
            end
            OP_LEV: begin
                x_sp  = fp_reg + SPW'(2);
                x_fp  = SPW'(top_reg);
                x_npc = w2_reg[PC_W-1:0];
                if (WORD_W'(fp_reg) + WORD_W'(2) > MEM64 || top_reg > MEM64) begin
                    x_st = ST_STACK;
                end else if (w2_reg >= PW64) begin
                    x_st = ST_ADDR;
                end
            end
            OP_LEA: begin
                x_acc = (WORD_W'(fp_reg) + opd_reg) << 3;
                x_npc = npc2;
            end
            OP_EXIT: begin
                x_exit = top;
                x_st   = ST_EXIT;
                x_sp   = SP_EMPTY;
                x_fp   = SP_EMPTY;
                x_npc  = entry_mod_reg;
                if (!can_pop) begin
                    x_st = ST_STACK;
                end
            end
            default: begin
                x_sp = sp_reg + SPW'(1);
                case (op_reg)
                    OP_OR:  x_acc = top | acc_reg;
                    OP_XOR: x_acc = top ^ acc_reg;
                    OP_AND: x_acc = top & acc_reg;
                    OP_EQ:  x_acc = WORD_W'(top == acc_reg);
                    OP_NE:  x_acc = WORD_W'(top != acc_reg);
                    OP_LT:  x_acc = WORD_W'($signed(top) < $signed(acc_reg));
                    OP_LE:  x_acc = WORD_W'($signed(top) <= $signed(acc_reg));
                    OP_GT:  x_acc = WORD_W'($signed(top) > $signed(acc_reg));
                    OP_GE:  x_acc = WORD_W'($signed(top) >= $signed(acc_reg));
                    OP_SHL: x_acc = top << acc_reg[5:0];
                    OP_SHR: x_acc = WORD_W'($signed(top) >>> acc_reg[5:0]);
                    OP_ADD: x_acc = top + acc_reg;
                    OP_SUB: x_acc = top - acc_reg;
                    OP_MUL: x_src = SRC_MUL;
                    default: x_src = SRC_DIV;
                endcase
                if (!can_pop) begin
                    x_st = ST_STACK;
                end else if ((op_reg == OP_DIV || op_reg == OP_MOD) && acc_reg == '0) begin
                    x_st = ST_DIV0;
                end
            end
        endcase

        // a fault leaves every piece of state alone
        if (x_st != ST_RUN && x_st != ST_EXIT) begin
            x_acc  = acc_reg;
            x_npc  = pc_reg;
            x_exit = '0;
            x_sp   = sp_reg;
            x_fp   = fp_reg;
            x_we   = 1'b0;
            x_src  = SRC_PLAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.plan) begin
            plan_acc_reg   <= x_acc;
            plan_exit_reg  <= x_exit;
            plan_npc_reg   <= x_npc;
            plan_st_reg    <= x_st;
            plan_sp_reg    <= x_sp;
            plan_fp_reg    <= x_fp;
            plan_we_reg    <= x_we;
            plan_waddr_reg <= x_waddr;
            plan_wdata_reg <= x_wdata;
            plan_src_reg   <= x_src;
        end
    end

    // ---------------- multiplier: three 32x32 products, then sum ----------------
    assign mul_x = (mul_cnt_reg == 3'd2) ? top_reg[63:32] : top_reg[31:0];
    assign mul_y = (mul_cnt_reg == 3'd1) ? acc_reg[63:32] : acc_reg[31:0];
    assign mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
        end else if (cmd.mul_go) begin
            mul_busy_reg <= 1'b1;
            mul_done_reg <= 1'b0;
        end else if (mul_busy_reg && mul_cnt_reg == 3'd3) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            mul_cnt_reg <= '0;
        end else if (mul_busy_reg) begin
            mul_cnt_reg <= mul_cnt_reg + 3'd1;
            case (mul_cnt_reg)
                3'd0:    prod_reg <= mul_p;
                3'd1:    cr1_reg  <= mul_p[31:0];
                3'd2:    cr2_reg  <= mul_p[31:0];
                default: mul_res_reg <= prod_reg + {cr1_reg + cr2_reg, 32'd0};
            endcase
        end
    end

    svm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .is_mod   (op_reg == OP_MOD),
        .dividend (top_reg),
        .divisor  (acc_reg),
        .done     (div_done),
        .result   (div_res)
    );

    // ---------------- commit ----------------
    always_comb begin
        case (plan_src_reg)
            SRC_MUL: fin_acc = mul_res_reg;
            SRC_DIV: fin_acc = div_res;
            default: fin_acc = plan_acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= '0;
            entry_mod_reg <= '0;
            acc_reg       <= '0;
            sp_reg        <= SP_EMPTY;
            fp_reg        <= SP_EMPTY;
        end else begin
            if (mod_busy_reg && mod_k_reg == 4'd0) begin
                entry_mod_reg <= mod_rem_next;
                pc_reg        <= mod_rem_next;
            end else if (cmd.commit) begin
                acc_reg <= fin_acc;
                sp_reg  <= plan_sp_reg;
                fp_reg  <= plan_fp_reg;
                pc_reg  <= plan_npc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_acc_reg  <= fin_acc;
            out_npc_reg  <= plan_npc_reg;
            out_st_reg   <= plan_st_reg;
            out_exit_reg <= plan_exit_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_exit_reg, out_npc_reg, out_acc_reg};
    assign m_tuser  = out_st_reg;

    always_comb begin
        sts.need2    = (op_reg == OP_SC) || (op_reg == OP_SI) || (op_reg == OP_LEV);
        sts.go_mul   = (x_src == SRC_MUL);
        sts.go_div   = (x_src == SRC_DIV);
        sts.mul_done = mul_done_reg;
        sts.div_done = div_done;
        sts.clr_last = (clr_cnt_reg == AW'(MEM_WORDS - 1));
        sts.cfg_busy = mod_busy_reg;
        sts.out_free = !out_valid_reg || m_tready;
    end

endmodule

>>> rtl/svm_ctrl.sv
// Controller: sequences memory clear, fetch, execute and commit of one instruction.
module svm_ctrl
    import svm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  svm_sts_t sts,
    output svm_cmd_t cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            CS_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = CS_IDLE;
                end
            end
            CS_IDLE: begin
                in_ready = !sts.cfg_busy;
                if (in_valid && !sts.cfg_busy) begin
                    cmd.load_item = 1'b1;
                    state_next    = CS_RD1;
                end
            end
            CS_RD1: begin
                cmd.rd1    = 1'b1;
                state_next = CS_CAP1;
            end
            CS_CAP1: begin
                cmd.cap1 = 1'b1;
                if (sts.need2) begin
                    cmd.rd2    = 1'b1;
                    state_next = CS_CAP2;
                end else begin
                    state_next = CS_EXEC;
                end
            end
            CS_CAP2: begin
                cmd.cap2   = 1'b1;
                state_next = CS_EXEC;
            end
            CS_EXEC: begin
                cmd.plan = 1'b1;
                if (sts.go_mul) begin
                    cmd.mul_go = 1'b1;
                    state_next = CS_MUL;
                end else if (sts.go_div) begin
                    cmd.div_go = 1'b1;
                    state_next = CS_DIV;
                end else begin
                    state_next = CS_WB;
                end
            end
            CS_MUL: begin
                if (sts.mul_done) begin
                    state_next = CS_WB;
                end
            end
            CS_DIV: begin
                if (sts.div_done) begin
                    state_next = CS_WB;
                end
            end
            CS_WB: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/stack_vm_execute_unit.sv
// Top level of the stack machine execute unit: controller plus datapath.
//
//  channel  dir  handshake                    payload
//  s_       in   s_tvalid / s_tready          tuser: op, tdata: operand
//  m_       out  m_tvalid / m_tready          tuser: status, tdata: acc, next_pc, exit_value
//  cfg_     in   cfg_wr_en (no back-pressure) cfg_wr_data: entry_pc
//
// Sequence: one instruction per beat. A plain op steps through accept, memory read,
// capture, execute and commit; m_tvalid is registered from the commit. Store and LEV
// add a second memory read. MUL runs on the shared 32x32 multiplier, DIV and MOD on
// the bit-serial divider.
// Reset: after aresetn the unit sweeps the stack memory to zero, one word per cycle,
// through all MEM_WORDS words, with s_tready low; a cfg write holds s_tready low while
// the entry index is reduced modulo PROG_WORDS.
// Stalls: a finished result sits in the output register; the next beat is accepted
// meanwhile, and its commit waits only until that result is taken.
module stack_vm_execute_unit
    import svm_pkg::*;
#(
    parameter int MEM_WORDS  = DEF_MEM_WORDS,
    parameter int PROG_WORDS = DEF_PROG_WORDS
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [63:0]       s_tdata,   // [63:0] operand
    input  logic [4:0]        s_tuser,   // [4:0] op
    // result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [143:0]      m_tdata,   // [63:0] acc, [79:64] next_pc, [143:80] exit_value
    output logic [2:0]        m_tuser,   // [2:0] status
    // entry point register
    input  logic              cfg_wr_en,
    input  logic [PC_W-1:0]   cfg_wr_data
);

    svm_cmd_t cmd;
    svm_sts_t sts;

    // controller decides when each datapath step fires
    svm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath holds pc, acc, sp, fp, stack memory and arithmetic units
    svm_datapath #(
        .MEM_WORDS  (MEM_WORDS),
        .PROG_WORDS (PROG_WORDS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_op       (s_tuser),
        .in_opd      (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // a result is committed only into a free output register
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("commit into occupied output register");

    // one instruction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second beat accepted while busy");

    // a new result appears only after a commit
    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // the multiplier and divider never start together
    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_go |-> !cmd.div_go && sts.go_mul)
        else $error("arithmetic unit start conflict");

endmodule

>>> tb/stack_vm_checker.sv
// Scoreboard for the stack machine execute unit: mirrors its state and checks every result beat.
`timescale 1ns / 1ps
module stack_vm_checker
    import svm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,
    input  logic [4:0]        s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [143:0]      m_tdata,
    input  logic [2:0]        m_tuser,
    input  logic              cfg_wr_en,
    input  logic [PC_W-1:0]   cfg_wr_data,
    output int                fail_count,
    output int                pending
);

    localparam int          WORDS     = DEF_MEM_WORDS;
    localparam logic [63:0] BYTE_SPAN = 64'(WORDS * 8);
    localparam logic [63:0] PROG_SPAN = 64'(DEF_PROG_WORDS);

    typedef struct packed {
        logic [63:0]     acc;
        logic [PC_W-1:0] next_pc;
        logic [2:0]      status;
        logic [63:0]     exit_value;
    } vm_result_t;

    logic [PC_W-1:0] entry_pc, pc;
    logic [63:0]     acc_reg;
    int unsigned     sp, fp;
    logic [63:0]     stack_mem [WORDS];
    vm_result_t      result_q [$];

    function automatic logic [63:0] mag(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    // Execute one instruction against the mirrored machine state.
    function automatic vm_result_t run_instr(op_t op, logic [63:0] opd);
        vm_result_t  r;
        logic [63:0] acc, top, nsp, a, b, sfp, ret, w, q;
        logic [2:0]  st;
        int unsigned nsp_i, nfp, sh;
        logic [PC_W-1:0] npc, npc2;
        logic        can_pop, take;
        acc     = acc_reg;
        nsp_i   = sp;
        nfp     = fp;
        npc     = pc + 1'b1;
        npc2    = pc + 2'd2;
        st      = ST_RUN;
        can_pop = sp < WORDS;
        top     = can_pop ? stack_mem[sp] : 64'd0;
        r.exit_value = '0;
        case (op)
            OP_IMM: begin
                acc = opd;
                npc = npc2;
            end
            OP_LC, OP_LI: begin
                if (acc >= BYTE_SPAN || (op == OP_LI && acc[2:0] != 0)) begin
                    st = ST_ADDR;
                end else if (op == OP_LI) begin
                    acc = stack_mem[acc >> 3];
                end else begin
                    w   = stack_mem[acc >> 3] >> (acc[2:0] * 8);
                    acc = {{56{w[7]}}, w[7:0]};
                end
            end
            OP_SC, OP_SI: begin
                if (!can_pop) begin
                    st = ST_STACK;
                end else if (top >= BYTE_SPAN || (op == OP_SI && top[2:0] != 0)) begin
                    st = ST_ADDR;
                end else begin
                    if (op == OP_SI) begin
                        stack_mem[top >> 3] = acc;
                    end else begin
                        sh = top[2:0] * 8;
                        w  = stack_mem[top >> 3];
                        w  = (w & ~(64'hFF << sh)) | ({56'd0, acc[7:0]} << sh);
                        stack_mem[top >> 3] = w;
                    end
                    nsp_i = sp + 1;
                end
            end
            OP_PUSH: begin
                if (sp == 0) begin
                    st = ST_STACK;
                end else begin
                    nsp_i = sp - 1;
                    stack_mem[nsp_i] = acc;
                end
            end
            OP_POP: begin
                if (!can_pop) begin
                    st = ST_STACK;
                end else begin
                    acc   = top;
                    nsp_i = sp + 1;
                end
            end
            OP_JMP, OP_JZ, OP_JNZ: begin
                take = op == OP_JMP || (op == OP_JZ && acc == 0) || (op == OP_JNZ && acc != 0);
                if (!take) npc = npc2;
                else if (opd >= PROG_SPAN) st = ST_ADDR;
                else npc = opd[PC_W-1:0];
            end
            OP_CALL: begin
                if (sp == 0) begin
                    st = ST_STACK;
                end else if (opd >= PROG_SPAN) begin
                    st = ST_ADDR;
                end else begin
                    nsp_i = sp - 1;
                    stack_mem[nsp_i] = 64'(npc2);
                    npc = opd[PC_W-1:0];
                end
            end
            OP_ENT: begin
                nsp = 64'(sp) - 64'd1 - opd;
                if (sp == 0 || nsp > 64'(WORDS)) begin
                    st = ST_STACK;
                end else begin
                    stack_mem[sp - 1] = 64'(fp);
                    nfp   = sp - 1;
                    nsp_i = 32'(nsp);
                    npc   = npc2;
                end
            end
            OP_ADJ: begin
                nsp = 64'(sp) + opd;
                if (nsp > 64'(WORDS)) begin
                    st = ST_STACK;
                end else begin
                    nsp_i = 32'(nsp);
                    npc   = npc2;
                end
            end
            OP_LEV: begin
                if (fp + 2 > WORDS) begin
                    st = ST_STACK;
                end else begin
                    sfp = stack_mem[fp];
                    ret = stack_mem[fp + 1];
                    if (sfp > 64'(WORDS)) st = ST_STACK;
                    else if (ret >= PROG_SPAN) st = ST_ADDR;
                    else begin
                        nsp_i = fp + 2;
                        nfp   = 32'(sfp);
                        npc   = ret[PC_W-1:0];
                    end
                end
            end
            OP_LEA: begin
                acc = (64'(fp) + opd) << 3;
                npc = npc2;
            end
            OP_EXIT: begin
                if (!can_pop) begin
                    st = ST_STACK;
                end else begin
                    r.exit_value = top;
                    st    = ST_EXIT;
                    nsp_i = WORDS;
                    nfp   = WORDS;
                    npc   = entry_pc;
                end
            end
            default: begin
                a = top;
                b = acc;
                if (!can_pop) st = ST_STACK;
                else if ((op == OP_DIV || op == OP_MOD) && b == 0) st = ST_DIV0;
                else begin
                    case (op)
                        OP_OR:  acc = a | b;
                        OP_XOR: acc = a ^ b;
                        OP_AND: acc = a & b;
                        OP_EQ:  acc = 64'(a == b);
                        OP_NE:  acc = 64'(a != b);
                        OP_LT:  acc = 64'($signed(a) < $signed(b));
                        OP_LE:  acc = 64'($signed(a) <= $signed(b));
                        OP_GT:  acc = 64'($signed(a) > $signed(b));
                        OP_GE:  acc = 64'($signed(a) >= $signed(b));
                        OP_SHL: acc = a << b[5:0];
                        OP_SHR: acc = $signed(a) >>> b[5:0];
                        OP_ADD: acc = a + b;
                        OP_SUB: acc = a - b;
                        OP_MUL: acc = a * b;
                        OP_DIV: begin
                            q   = mag(a) / mag(b);
                            acc = (a[63] != b[63]) ? 64'd0 - q : q;
                        end
                        default: begin
                            q   = mag(a) % mag(b);
                            acc = a[63] ? 64'd0 - q : q;
                        end
                    endcase
                    nsp_i = sp + 1;
                end
            end
        endcase
        r.status = st;
        if (st != ST_RUN && st != ST_EXIT) begin
            r.acc        = acc_reg;
            r.next_pc    = pc;
            r.exit_value = '0;
        end else begin
            acc_reg   = acc;
            sp        = nsp_i;
            fp        = nfp;
            pc        = npc;
            r.acc     = acc;
            r.next_pc = npc;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        vm_result_t got, want;
        if (!aresetn) begin
            entry_pc = '0;
            pc       = '0;
            acc_reg  = '0;
            sp       = WORDS;
            fp       = WORDS;
            foreach (stack_mem[i]) stack_mem[i] = '0;
            result_q.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[63:0], m_tdata[79:64], m_tuser, m_tdata[143:80]};
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (cfg_wr_en) begin
                entry_pc = cfg_wr_data;
                pc       = cfg_wr_data;
            end
            if (s_tvalid && s_tready) result_q = {result_q, run_instr(op_t'(s_tuser), s_tdata)};
            pending = result_q.size();
        end
    end

endmodule

>>> tb/tb_stack_vm_execute_unit.sv
// Testbench top for the stack machine execute unit: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module tb_stack_vm_execute_unit;
    import svm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata = '0;
    logic [4:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [143:0]      m_tdata;
    logic [2:0]        m_tuser;
    logic              cfg_wr_en = 1'b0;
    logic [PC_W-1:0]   cfg_wr_data = '0;
    int                fail_count, pending, cycles = 0;
    logic              idle_on = 1'b1;

    always #6 aclk = ~aclk;

    stack_vm_execute_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    stack_vm_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Stall the result side about ten percent of the time while idling is on.
    always @(negedge aclk) begin
        m_tready <= idle_on ? ($urandom_range(99) >= 10) : 1'b1;
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Drive one instruction beat, with an occasional gap ahead of it, and hold until taken.
    task automatic send(op_t op, logic [63:0] opd);
        while (idle_on && $urandom_range(99) < 10) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = opd;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Drain all outstanding results, then let the pipeline settle.
    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_entry(logic [PC_W-1:0] v);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Data value with bias toward the edges of the signed range.
    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '1;
            3: return 64'($urandom_range(70));
            default: return rand64();
        endcase
    endfunction

    // Byte address: mostly legal, sometimes misaligned or past the end of memory.
    function automatic logic [63:0] pick_addr(logic word);
        case ($urandom_range(9))
            0: return 64'(8192 + $urandom_range(100));
            1: return rand64();
            2: return 64'($urandom_range(8191));
            default: return word ? 64'($urandom_range(1023) * 8) : 64'($urandom_range(8191));
        endcase
    endfunction

    function automatic logic [63:0] pick_target();
        return ($urandom_range(19) == 0) ? rand64() : 64'($urandom_range(65535));
    endfunction

    function automatic logic [63:0] pick_small();
        return ($urandom_range(9) == 0) ? rand64() : 64'($signed($urandom_range(16)) - 8);
    endfunction

    // One random instruction with an operand shaped to its op.
    task automatic send_any();
        op_t op;
        logic [63:0] opd;
        op = op_t'($urandom_range(31));
        case (op)
            OP_IMM:                     opd = $urandom_range(1) ? pick_value() : pick_addr(1'b1);
            OP_JMP, OP_JZ, OP_JNZ, OP_CALL: opd = pick_target();
            OP_ENT, OP_ADJ, OP_LEA:     opd = pick_small();
            default:                    opd = rand64();
        endcase
        send(op, opd);
    endtask

    // Emit one well-formed sequence or a lone instruction; return beats sent.
    task automatic send_sequence(output int n);
        int k;
        k = $urandom_range(99);
        if (k < 40) begin
            send_any();
            n = 1;
        end else if (k < 58) begin
            // store: address, push it, value, store
            k = $urandom_range(1);
            send(OP_IMM, pick_addr(k[0]));
            send(OP_PUSH, rand64());
            send(OP_IMM, pick_value());
            send(k[0] ? OP_SI : OP_SC, rand64());
            n = 4;
        end else if (k < 68) begin
            k = $urandom_range(1);
            send(OP_IMM, pick_addr(k[0]));
            send(k[0] ? OP_LI : OP_LC, rand64());
            n = 2;
        end else if (k < 82) begin
            // binary op on two operands
            send(OP_IMM, pick_value());
            send(OP_PUSH, rand64());
            send(OP_IMM, pick_value());
            send(op_t'($urandom_range(int'(OP_OR), int'(OP_MOD))), rand64());
            n = 4;
        end else if (k < 95) begin
            // call frame: call, enter, use a local, leave
            send(OP_CALL, 64'($urandom_range(65535)));
            send(OP_ENT, 64'($urandom_range(4)));
            send(OP_LEA, pick_small());
            send(OP_PUSH, rand64());
            send(OP_IMM, pick_value());
            send(OP_SI, rand64());
            send(OP_LEV, rand64());
            n = 7;
        end else begin
            send(OP_IMM, pick_value());
            send(OP_PUSH, rand64());
            send(OP_EXIT, rand64());
            n = 3;
        end
    endtask

    initial begin
        int sent, n, phase;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: faults, division corners, jumps at the edges, stack limits.
        idle_on = 1'b1;
        write_entry(16'hFFFF);
        send(OP_POP, '0);
        send(OP_IMM, 64'h8000_0000_0000_0000);
        send(OP_PUSH, '1);
        send(OP_IMM, '1);
        send(OP_DIV, '0);
        send(OP_PUSH, '0);
        send(OP_IMM, '0);
        send(OP_MOD, '0);
        send(OP_IMM, 64'd70);
        send(OP_SHR, '0);
        send(OP_IMM, 64'd12);
        send(OP_LI, '0);
        send(OP_IMM, 64'd8192);
        send(OP_LC, '0);
        send(OP_JMP, 64'd65536);
        send(OP_JZ, 64'h7FFF_FFFF_FFFF_FFFF);
        send(OP_LEV, '0);
        send(OP_ENT, 64'h8000_0000_0000_0000);
        send(OP_ADJ, 64'hFFFF_FFFF_FFFF_FC00);
        send(OP_PUSH, '0);
        send(OP_ADJ, 64'd1024);
        send(OP_CALL, 64'd65535);
        send(OP_EXIT, '0);
        send(OP_EXIT, '0);

        // Random phases across several entry points; the third one runs without idling.
        sent = 0;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_entry('0);
                1: write_entry(16'($urandom));
                2: write_entry(16'hFFFF);
                default: write_entry(16'd1);
            endcase
            idle_on = (phase != 2);
            while (sent < (phase + 1) * 460) begin
                send_sequence(n);
                sent += n;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
